@@ design/ppurv_pkg.sv @@
// Shared types and codes for the video processor register port.
// No dependencies; every other design file refers to this package.
package ppurv_pkg;

	// Nametable RAM: 2 KB, two 1 KB tables
	localparam int unsigned NAME_AW = 11;

	// Command codes
	localparam logic [2:0] CMD_READ      = 3'd0;
	localparam logic [2:0] CMD_WRITE     = 3'd1;
	localparam logic [2:0] CMD_PEEK      = 3'd2;
	localparam logic [2:0] CMD_VBL_BEGIN = 3'd3;
	localparam logic [2:0] CMD_VBL_END   = 3'd4;

	// Register numbers
	localparam logic [2:0] REG_CTRL    = 3'd0;
	localparam logic [2:0] REG_MASK    = 3'd1;
	localparam logic [2:0] REG_STATUS  = 3'd2;
	localparam logic [2:0] REG_OAMADDR = 3'd3;
	localparam logic [2:0] REG_OAMDATA = 3'd4;
	localparam logic [2:0] REG_SCROLL  = 3'd5;
	localparam logic [2:0] REG_ADDR    = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	// Mirroring modes
	localparam logic [1:0] MIR_VERT   = 2'd0;
	localparam logic [1:0] MIR_HORZ   = 2'd1;
	localparam logic [1:0] MIR_ONE_LO = 2'd2;
	localparam logic [1:0] MIR_ONE_HI = 2'd3;

	typedef struct packed {
		logic [2:0] command;
		logic [2:0] reg_index;
		logic [7:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_pulse;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic               clr_en;
		logic [NAME_AW-1:0] clr_addr;
		logic               capture;
		logic               commit;
	} ctl_t;

endpackage

@@ design/ppurv_ctrl.sv @@
// Sequencer for the register port: nametable clearing pass, accept, commit.
// Depends on ppurv_pkg.
module ppurv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ppurv_pkg::ctl_t ctl
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                        state_q;
	logic [ppurv_pkg::NAME_AW-1:0] clr_cnt_q;
	logic                          rsp_valid_q;
	logic                          slot_free;

	assign slot_free   = !rsp_valid_q || rsp_ready;
	assign req_ready   = (state_q == ST_IDLE);
	assign rsp_valid   = rsp_valid_q;

	assign ctl.clr_en   = (state_q == ST_CLEAR);
	assign ctl.clr_addr = clr_cnt_q;
	assign ctl.capture  = req_valid && req_ready;
	assign ctl.commit   = (state_q == ST_EXEC) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (&clr_cnt_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/ppurv_datapath.sv @@
// Register file, OAM, nametable and palette RAMs, and result register.
// Depends on ppurv_pkg; sequenced by ppurv_ctrl through ctl_t.
module ppurv_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  ppurv_pkg::ctl_t ctl,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_data,
	input  ppurv_pkg::req_t req,
	output ppurv_pkg::rsp_t rsp
);

	localparam int unsigned AW = ppurv_pkg::NAME_AW;

	function automatic logic [AW-1:0] name_slot(input logic [15:0] a, input logic [1:0] mode);
		logic tbl;
		unique case (mode)
			ppurv_pkg::MIR_VERT:   tbl = a[10];
			ppurv_pkg::MIR_HORZ:   tbl = a[11];
			ppurv_pkg::MIR_ONE_LO: tbl = 1'b0;
			ppurv_pkg::MIR_ONE_HI: tbl = 1'b1;
			default:               tbl = 1'b0;
		endcase
		return {tbl, a[9:0]};
	endfunction

	// Backdrop mirrors: 0x10/0x14/0x18/0x1C fold onto 0x00/0x04/0x08/0x0C
	function automatic logic [4:0] pal_slot(input logic [4:0] a);
		return (a[4] && (a[1:0] == 2'b00)) ? {1'b0, a[3:0]} : a;
	endfunction

	// Architectural registers
	logic [1:0]  mirror_q;
	logic [7:0]  ctrl_q, mask_q, buf_q, spr_addr_q;
	logic        vbl_q, tog_q;
	logic [14:0] t_q;
	logic [15:0] cur_q;
	logic [7:0]  pal_q [0:31];
	logic [255:0] spr_vld_q;

	// Memories and their registered read ports
	logic [7:0]  name_mem_q [0:(1<<AW)-1];
	logic [7:0]  spr_mem_q [0:255];
	logic [7:0]  name_rd_q, spr_rd_q;
	logic        spr_vld_rd_q;

	ppurv_pkg::req_t item_q;
	ppurv_pkg::rsp_t rsp_q;

	// Next-state values
	logic [7:0]  ctrl_d, mask_d, buf_d, oam_d, rd;
	logic        vbl_d, tog_d, nmi;
	logic [14:0] t_d;
	logic [15:0] cur_d, step;
	logic        name_we, pal_we, spr_we;
	logic [13:0] a14;
	logic        in_pal, in_name;
	logic [4:0]  pal_idx;
	logic [7:0]  vram_val, spr_val;

	assign a14      = cur_q[13:0];
	assign in_pal   = (a14 >= 14'h3F00);
	assign in_name  = (a14 >= 14'h2000) && !in_pal;
	assign pal_idx  = pal_slot(cur_q[4:0]);
	assign vram_val = in_pal ? pal_q[pal_idx] : (in_name ? name_rd_q : 8'h00);
	assign spr_val  = spr_vld_rd_q ? spr_rd_q : 8'h00;
	assign step     = ctrl_q[2] ? 16'd32 : 16'd1;

	always_comb begin
		ctrl_d  = ctrl_q;
		mask_d  = mask_q;
		vbl_d   = vbl_q;
		tog_d   = tog_q;
		t_d     = t_q;
		cur_d   = cur_q;
		buf_d   = buf_q;
		oam_d   = spr_addr_q;
		name_we = 1'b0;
		pal_we  = 1'b0;
		spr_we  = 1'b0;
		rd      = 8'h00;
		nmi     = 1'b0;
		unique case (item_q.command)
			ppurv_pkg::CMD_READ: begin
				case (item_q.reg_index)
					ppurv_pkg::REG_STATUS: begin
						rd    = {vbl_q, 2'b00, buf_q[4:0]};
						vbl_d = 1'b0;
						tog_d = 1'b0;
					end
					ppurv_pkg::REG_OAMDATA: rd = spr_val;
					ppurv_pkg::REG_DATA: begin
						rd    = in_pal ? vram_val : buf_q;
						buf_d = vram_val;
						cur_d = cur_q + step;
					end
					default: rd = 8'h00;
				endcase
			end
			ppurv_pkg::CMD_WRITE: begin
				case (item_q.reg_index)
					ppurv_pkg::REG_CTRL: begin
						ctrl_d     = item_q.write_data;
						t_d[11:10] = item_q.write_data[1:0];
					end
					ppurv_pkg::REG_MASK:    mask_d = item_q.write_data;
					ppurv_pkg::REG_OAMADDR: oam_d  = item_q.write_data;
					ppurv_pkg::REG_OAMDATA: spr_we = 1'b1;
					ppurv_pkg::REG_SCROLL: begin
						if (!tog_q) begin
							t_d[4:0] = item_q.write_data[7:3];
						end else begin
							t_d[14:12] = item_q.write_data[2:0];
							t_d[9:5]   = item_q.write_data[7:3];
						end
						tog_d = !tog_q;
					end
					ppurv_pkg::REG_ADDR: begin
						if (!tog_q) begin
							t_d = {1'b0, item_q.write_data[5:0], t_q[7:0]};
						end else begin
							t_d   = {t_q[14:8], item_q.write_data};
							cur_d = {1'b0, t_q[14:8], item_q.write_data};
						end
						tog_d = !tog_q;
					end
					ppurv_pkg::REG_DATA: begin
						name_we = in_name;
						pal_we  = in_pal;
						cur_d   = cur_q + step;
					end
					default: ;
				endcase
			end
			ppurv_pkg::CMD_PEEK: begin
				case (item_q.reg_index)
					ppurv_pkg::REG_CTRL:    rd = ctrl_q;
					ppurv_pkg::REG_MASK:    rd = mask_q;
					ppurv_pkg::REG_STATUS:  rd = {vbl_q, 7'h00};
					ppurv_pkg::REG_OAMDATA: rd = spr_val;
					ppurv_pkg::REG_DATA:    rd = buf_q;
					default:                rd = 8'h00;
				endcase
			end
			ppurv_pkg::CMD_VBL_BEGIN: begin
				vbl_d = 1'b1;
				nmi   = ctrl_q[7];
			end
			ppurv_pkg::CMD_VBL_END: vbl_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q   <= ppurv_pkg::MIR_VERT;
			ctrl_q     <= '0;
			mask_q     <= '0;
			vbl_q      <= 1'b0;
			tog_q      <= 1'b0;
			t_q        <= '0;
			cur_q      <= '0;
			buf_q      <= '0;
			spr_addr_q <= '0;
			spr_vld_q  <= '0;
			for (int i = 0; i < 32; i++) begin
				pal_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				mirror_q <= cfg_data;
			end
			if (ctl.commit) begin
				ctrl_q     <= ctrl_d;
				mask_q     <= mask_d;
				vbl_q      <= vbl_d;
				tog_q      <= tog_d;
				t_q        <= t_d;
				cur_q      <= cur_d;
				buf_q      <= buf_d;
				spr_addr_q <= oam_d;
				if (pal_we) begin
					pal_q[pal_idx] <= item_q.write_data;
				end
				if (spr_we) begin
					spr_vld_q[spr_addr_q] <= 1'b1;
				end
			end
		end
	end

	// Nametable RAM: one write port shared with the clearing pass
	always_ff @(posedge clk) begin
		if (ctl.clr_en) begin
			name_mem_q[ctl.clr_addr] <= 8'h00;
		end else if (ctl.commit && name_we) begin
			name_mem_q[name_slot(cur_q, mirror_q)] <= item_q.write_data;
		end
		name_rd_q <= name_mem_q[name_slot(cur_q, mirror_q)];
	end

	// OAM: unwritten entries masked by valid bits
	always_ff @(posedge clk) begin
		if (ctl.commit && spr_we) begin
			spr_mem_q[spr_addr_q] <= item_q.write_data;
		end
		spr_rd_q     <= spr_mem_q[spr_addr_q];
		spr_vld_rd_q <= spr_vld_q[spr_addr_q];
	end

	// Item and result registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= req;
		end
		if (ctl.commit) begin
			rsp_q.read_data <= rd;
			rsp_q.nmi_pulse <= nmi;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ design/ppu_register_port_vram_top.sv @@
// Top level of the video processor CPU register port with its VRAM.
// Depends on ppurv_pkg, ppurv_ctrl and ppurv_datapath.
//
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------
// request  | req_valid / req_ready  | req: command, reg_index, write_data
// response | rsp_valid / rsp_ready  | rsp: read_data, nmi_pulse
// config   | cfg_valid / cfg_ready  | cfg_data: mirror_mode
//
// For each item, the accept cycle addresses the nametable and OAM RAMs, whose
// registered read data is used in the execute state, where the item commits
// its register and memory updates and loads the response register once the
// response slot is free. One item is in flight at a time.
// After reset the nametable RAM is swept to zero, all 2048 bytes, one byte a
// cycle; req_ready stays low during the sweep, config writes are taken.
// A held response stalls the commit only; the next item is taken as soon as
// the previous one has committed, while its response still waits.
module ppu_register_port_vram_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ppurv_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ppurv_pkg::rsp_t rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_data
);

	ppurv_pkg::ctl_t ctl;

	// Mirroring register is always writable
	assign cfg_ready = 1'b1;

	ppurv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	ppurv_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp)
	);

	// No item taken during the nametable sweep
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.clr_en && req_ready))
		else $error("item accepted during nametable clearing");

	// A commit never overwrites a response that is not being taken
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!rsp_valid || rsp_ready))
		else $error("response overwritten");

	// Every commit presents a response next cycle
	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> rsp_valid)
		else $error("commit without response");

	// One item at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> !req_ready)
		else $error("second item accepted before commit");

endmodule
